// ----- hdl/drp_pkg.sv -----
// ----------------------------------------------------------------------------
// drp_pkg
// Types and constants shared by the depth ROI point projection block.
// ----------------------------------------------------------------------------
package drp_pkg;

  localparam int COORD_W  = 12;
  localparam int DEPTH_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int CENTER_W = 16;
  localparam int INV_W    = 24;
  localparam int ORDER_W  = 2;
  localparam int POS_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int MAG_W    = 16;
  localparam int MUL_A_W  = 24;
  localparam int MUL_B_W  = 16;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 56;
  localparam int FRAC_SHIFT = 20;
  localparam int Q_W      = ACC_W - FRAC_SHIFT;

  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(20'hFFFFF);
  localparam logic [Q_W-1:0]   Q_POS_MAX  = Q_W'(32'h7FFF_FFFF);
  localparam logic [Q_W-1:0]   Q_NEG_MAX  = Q_W'(32'h8000_0000);
  localparam logic [POS_W-1:0] SAT_POS    = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0] SAT_NEG    = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_PRINC_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRINC_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ORDER = 3'd4;

  localparam logic [CENTER_W-1:0] PRINC_X_RST   = 16'd5120;
  localparam logic [CENTER_W-1:0] PRINC_Y_RST   = 16'd3840;
  localparam logic [INV_W-1:0]    INV_FOCAL_RST = 24'd31957;

  localparam logic [ORDER_W-1:0] COLOR_RGB  = 2'd0;
  localparam logic [ORDER_W-1:0] COLOR_BGR  = 2'd1;
  localparam logic [ORDER_W-1:0] COLOR_MONO = 2'd2;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ADD_BOX = 2'd1,
    OP_PIXEL   = 2'd2,
    OP_END     = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BOX_RD,
    S_BOX_CMP,
    S_PREP,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_RND,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
  } box_t;

  typedef struct packed {
    logic en;
    box_t box;
  } box_wr_t;

endpackage

// ----- hdl/drp_in_if.sv -----
// ----------------------------------------------------------------------------
// drp_in_if
// Input item channel: operation, pixel and box fields.
// ----------------------------------------------------------------------------
interface drp_in_if import drp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [COORD_W-1:0] pix_u;
  logic [COORD_W-1:0] pix_v;
  logic [DEPTH_W-1:0] depth_mm;
  logic [BYTE_W-1:0]  byte0;
  logic [BYTE_W-1:0]  byte1;
  logic [BYTE_W-1:0]  byte2;
  logic [COORD_W-1:0] box_left;
  logic [COORD_W-1:0] box_top;
  logic [COORD_W-1:0] box_width;
  logic [COORD_W-1:0] box_height;

  modport source (
    output valid, operation, pix_u, pix_v, depth_mm, byte0, byte1, byte2,
           box_left, box_top, box_width, box_height,
    input  ready
  );
  modport sink (
    input  valid, operation, pix_u, pix_v, depth_mm, byte0, byte1, byte2,
           box_left, box_top, box_width, box_height,
    output ready
  );
endinterface

// ----- hdl/drp_out_if.sv -----
// ----------------------------------------------------------------------------
// drp_out_if
// Result channel: point results and end of frame reports.
// ----------------------------------------------------------------------------
interface drp_out_if import drp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic                     point_valid;
  logic signed [POS_W-1:0]  x_mm;
  logic signed [POS_W-1:0]  y_mm;
  logic [DEPTH_W-1:0]       z_mm;
  logic [BYTE_W-1:0]        red;
  logic [BYTE_W-1:0]        green;
  logic [BYTE_W-1:0]        blue;
  logic                     any_in_box;
  logic                     box_overflow;

  modport source (
    output valid, result_kind, point_valid, x_mm, y_mm, z_mm, red, green, blue,
           any_in_box, box_overflow,
    input  ready
  );
  modport sink (
    input  valid, result_kind, point_valid, x_mm, y_mm, z_mm, red, green, blue,
           any_in_box, box_overflow,
    output ready
  );
endinterface

// ----- hdl/drp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// drp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface drp_cfg_if import drp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/drp_box_table.sv -----
// ----------------------------------------------------------------------------
// drp_box_table
// Box table memory with registered read and inclusive bounds test.
// ----------------------------------------------------------------------------
module drp_box_table import drp_pkg::*; #(
  parameter int MAX_BOXES = 8,
  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
  input  logic               clk,
  input  box_wr_t            wr,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  input  logic [COORD_W-1:0] pix_u,
  input  logic [COORD_W-1:0] pix_v,
  output logic               hit
);

  box_t mem [MAX_BOXES];
  box_t rd_box_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.box;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_box_r <= mem[rd_addr];
    end
  end

  logic [COORD_W:0] right_edge;
  logic [COORD_W:0] bottom_edge;

  always_comb begin
    right_edge  = {1'b0, rd_box_r.left} + {1'b0, rd_box_r.width};
    bottom_edge = {1'b0, rd_box_r.top} + {1'b0, rd_box_r.height};
    hit = (pix_u >= rd_box_r.left) && ({1'b0, pix_u} <= right_edge) &&
          (pix_v >= rd_box_r.top)  && ({1'b0, pix_v} <= bottom_edge);
  end

endmodule

// ----- hdl/drp_mul.sv -----
// ----------------------------------------------------------------------------
// drp_mul
// Shared unsigned 24x16 multiplier with registered product.
// ----------------------------------------------------------------------------
module drp_mul import drp_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

// ----- hdl/depth_roi_point_projection_core.sv -----
// Start and add-box items are taken in S_IDLE. An end report moves to S_EMIT and is
// loaded into the output register once that register is free. A pixel probes the
// boxes (S_BOX_RD, S_BOX_CMP) in turn and projects both axes for a valid point.
// One item at a time: the next transfer is taken once the result is loaded. The
// box scan (one memory port) and a single 24x16 multiplier used three times per
// axis set the item time. Reset: clears box count and flags, sets config defaults.
// ----------------------------------------------------------------------------
// depth_roi_point_projection_core
// Pinhole back-projection of depth pixels that fall inside a table of boxes.
// ----------------------------------------------------------------------------
module depth_roi_point_projection_core import drp_pkg::*; #(
  parameter int MAX_BOXES = 8
) (
  input logic      clk,
  input logic      rst_n,
  drp_in_if.sink   in_ch,
  drp_out_if.source out_ch,
  drp_cfg_if.sink  cfg_ch
);

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  // config
  logic [CENTER_W-1:0] princ_x_r, princ_y_r;
  logic [INV_W-1:0]    inv_fx_r, inv_fy_r;
  logic [ORDER_W-1:0]  color_order_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      princ_x_r     <= PRINC_X_RST;
      princ_y_r     <= PRINC_Y_RST;
      inv_fx_r      <= INV_FOCAL_RST;
      inv_fy_r      <= INV_FOCAL_RST;
      color_order_r <= COLOR_RGB;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_PRINC_X:     princ_x_r     <= cfg_ch.data[CENTER_W-1:0];
        CFG_PRINC_Y:     princ_y_r     <= cfg_ch.data[CENTER_W-1:0];
        CFG_INV_FOCAL_X: inv_fx_r      <= cfg_ch.data[INV_W-1:0];
        CFG_INV_FOCAL_Y: inv_fy_r      <= cfg_ch.data[INV_W-1:0];
        CFG_COLOR_ORDER: color_order_r <= cfg_ch.data[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] box_count_r, box_count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             hit_r, hit_nxt;
  logic             ovf_r, ovf_nxt;
  logic             in_box_r, in_box_nxt;
  logic             report_r, report_nxt;
  logic             ax_r, ax_nxt;
  logic             out_valid_r, out_valid_nxt;

  // item and datapath
  logic [COORD_W-1:0] u_r, v_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [BYTE_W-1:0]  b0_r, b1_r, b2_r;
  logic               neg_r;
  logic [MAG_W-1:0]   mag_r;
  logic [15:0]        md_hi_r;
  logic [ACC_W-1:0]   acc_r;
  logic [POS_W-1:0]   x_r, y_r;

  // output register
  logic               o_kind_r, o_pv_r, o_any_r, o_ovf_r;
  logic [POS_W-1:0]   o_x_r, o_y_r;
  logic [DEPTH_W-1:0] o_z_r;
  logic [BYTE_W-1:0]  o_red_r, o_green_r, o_blue_r;

  logic in_xfer;
  logic emit;
  op_t  op;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign op          = op_t'(in_ch.operation);
  assign emit        = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // box table
  box_wr_t box_wr;
  logic    box_hit;

  always_comb begin
    box_wr.en         = in_xfer && (op == OP_ADD_BOX) &&
                        (box_count_r < CNT_W'(MAX_BOXES));
    box_wr.box.left   = in_ch.box_left;
    box_wr.box.top    = in_ch.box_top;
    box_wr.box.width  = in_ch.box_width;
    box_wr.box.height = in_ch.box_height;
  end

  drp_box_table #(.MAX_BOXES(MAX_BOXES)) u_box_table (
    .clk     (clk),
    .wr      (box_wr),
    .wr_addr (box_count_r[IDX_W-1:0]),
    .rd_en   (state_r == S_BOX_RD),
    .rd_addr (idx_r[IDX_W-1:0]),
    .pix_u   (u_r),
    .pix_v   (v_r),
    .hit     (box_hit)
  );

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [INV_W-1:0]   inv_sel;

  assign inv_sel = ax_r ? inv_fy_r : inv_fx_r;

  always_comb begin
    case (state_r)
      S_MUL0: begin
        mul_a = MUL_A_W'(depth_r);
        mul_b = mag_r;
      end
      S_MUL1: begin
        mul_a = inv_sel;
        mul_b = mul_p[15:0];
      end
      default: begin
        mul_a = inv_sel;
        mul_b = md_hi_r;
      end
    endcase
  end

  drp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // axis prep and rounding
  logic [CENTER_W-1:0] pix_fx;
  logic [CENTER_W-1:0] center_sel;
  logic                neg_calc;
  logic [MAG_W-1:0]    mag_calc;
  logic [Q_W-1:0]      q;
  logic [POS_W-1:0]    axis_res;

  always_comb begin
    pix_fx     = ax_r ? {v_r, 4'b0000} : {u_r, 4'b0000};
    center_sel = ax_r ? princ_y_r : princ_x_r;
    neg_calc   = pix_fx < center_sel;
    mag_calc   = neg_calc ? (center_sel - pix_fx) : (pix_fx - center_sel);
    q          = acc_r[ACC_W-1:FRAC_SHIFT];
    if (!neg_r) begin
      axis_res = (q > Q_POS_MAX) ? SAT_POS : q[POS_W-1:0];
    end else begin
      axis_res = (q > Q_NEG_MAX) ? SAT_NEG : (POS_W'(0) - q[POS_W-1:0]);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    box_count_nxt = box_count_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    ovf_nxt       = ovf_r;
    in_box_nxt    = in_box_r;
    report_nxt    = report_r;
    ax_nxt        = ax_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (op)
            OP_START: begin
              box_count_nxt = '0;
              hit_nxt       = 1'b0;
              ovf_nxt       = 1'b0;
            end
            OP_ADD_BOX: begin
              if (box_count_r < CNT_W'(MAX_BOXES)) begin
                box_count_nxt = box_count_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_PIXEL: begin
              report_nxt = 1'b0;
              in_box_nxt = 1'b0;
              idx_nxt    = '0;
              ax_nxt     = 1'b0;
              state_nxt  = (box_count_r == '0) ? S_EMIT : S_BOX_RD;
            end
            OP_END: begin
              report_nxt = 1'b1;
              state_nxt  = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_BOX_RD: state_nxt = S_BOX_CMP;
      S_BOX_CMP: begin
        if (box_hit) begin
          in_box_nxt = 1'b1;
          hit_nxt    = 1'b1;
          state_nxt  = (depth_r != '0) ? S_PREP : S_EMIT;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = (idx_nxt == box_count_r) ? S_EMIT : S_BOX_RD;
        end
      end
      S_PREP: state_nxt = S_MUL0;
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_ACC;
      S_ACC:  state_nxt = S_RND;
      S_RND: begin
        if (!ax_r) begin
          ax_nxt    = 1'b1;
          state_nxt = S_PREP;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      box_count_r <= '0;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      ovf_r       <= 1'b0;
      in_box_r    <= 1'b0;
      report_r    <= 1'b0;
      ax_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      box_count_r <= box_count_nxt;
      idx_r       <= idx_nxt;
      hit_r       <= hit_nxt;
      ovf_r       <= ovf_nxt;
      in_box_r    <= in_box_nxt;
      report_r    <= report_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer && (op == OP_PIXEL)) begin
      u_r     <= in_ch.pix_u;
      v_r     <= in_ch.pix_v;
      depth_r <= in_ch.depth_mm;
      b0_r    <= in_ch.byte0;
      b1_r    <= in_ch.byte1;
      b2_r    <= in_ch.byte2;
    end
    case (state_r)
      S_PREP: begin
        neg_r <= neg_calc;
        mag_r <= mag_calc;
      end
      S_MUL1: md_hi_r <= mul_p[31:16];
      S_MUL2: acc_r <= ACC_W'(mul_p) + (neg_r ? ROUND_BIAS : '0);
      S_ACC:  acc_r <= acc_r + {mul_p[ACC_W-17:0], 16'h0000};
      S_RND: begin
        if (!ax_r) begin
          x_r <= axis_res;
        end else begin
          y_r <= axis_res;
        end
      end
      default: ;
    endcase
  end

  // output register load
  logic pv;
  assign pv = in_box_r && (depth_r != '0);

  always_ff @(posedge clk) begin
    if (emit) begin
      o_kind_r <= report_r;
      o_any_r  <= report_r && hit_r;
      o_ovf_r  <= report_r && ovf_r;
      o_pv_r   <= !report_r && pv;
      o_x_r    <= (!report_r && pv) ? x_r : '0;
      o_y_r    <= (!report_r && pv) ? y_r : '0;
      o_z_r    <= (!report_r && pv) ? depth_r : '0;
      if (report_r) begin
        o_red_r   <= '0;
        o_green_r <= '0;
        o_blue_r  <= '0;
      end else begin
        case (color_order_r)
          COLOR_BGR: begin
            o_red_r   <= b2_r;
            o_green_r <= b1_r;
            o_blue_r  <= b0_r;
          end
          COLOR_MONO: begin
            o_red_r   <= b0_r;
            o_green_r <= b0_r;
            o_blue_r  <= b0_r;
          end
          default: begin
            o_red_r   <= b0_r;
            o_green_r <= b1_r;
            o_blue_r  <= b2_r;
          end
        endcase
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = o_kind_r;
  assign out_ch.point_valid  = o_pv_r;
  assign out_ch.x_mm         = o_x_r;
  assign out_ch.y_mm         = o_y_r;
  assign out_ch.z_mm         = o_z_r;
  assign out_ch.red          = o_red_r;
  assign out_ch.green        = o_green_r;
  assign out_ch.blue         = o_blue_r;
  assign out_ch.any_in_box   = o_any_r;
  assign out_ch.box_overflow = o_ovf_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    box_count_r <= CNT_W'(MAX_BOXES))
    else $error("box count beyond table depth");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (op == OP_START)) |=> (box_count_r == '0) && !hit_r && !ovf_r)
    else $error("start item did not clear frame state");

  a_valid_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_pv_r) |-> (o_z_r != '0) && !o_kind_r)
    else $error("valid point with zero depth or on a report");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BOX_RD) |-> (idx_r < box_count_r))
    else $error("box scan past filled entries");

endmodule
